// ===== hdl/otq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_pkg
// Shared types, sizes and codes of the one-shot timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

  localparam int SLOTS       = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

  typedef logic [TIME_BITS-1:0] tstamp_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam tstamp_t TIME_MAX = '1;

  // Request codes. The last code is unused and does nothing.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SCHED  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] delay_ms;
    logic [31:0] target_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_handle;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_SCHED,
    OP_CANCEL,
    OP_EXPIRE
  } op_t;

  // Token that walks down the cell row, one cell per cycle.
  typedef struct packed {
    logic        active;
    op_t         op;
    logic        found;
    logic        kill;
    idx_t        kill_idx;
    tstamp_t     due;
    logic [31:0] handle;
    idx_t        idx;
  } carry_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAVE
  } state_t;

endpackage

// ===== hdl/otq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_cell
// One timer slot: holds valid, due time and handle, and updates the token
// that passes through it on its way down the row.
// ----------------------------------------------------------------------------
module otq_cell
  import otq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  idx_t    my_idx,
  input  tstamp_t now_ms,
  input  carry_t  carry_in,
  output carry_t  carry_out
);

  logic        valid;
  tstamp_t     due;
  logic [31:0] handle;

  logic        valid_next;
  tstamp_t     due_next;
  logic [31:0] handle_next;
  carry_t      carry_next;
  logic        kill_me;
  logic        valid_eff;
  logic        better;

  always_comb begin
    kill_me    = carry_in.active && carry_in.kill && (carry_in.kill_idx == my_idx);
    valid_eff  = valid && !kill_me;
    valid_next = carry_in.active ? valid_eff : valid;
    due_next   = due;
    handle_next = handle;
    carry_next = carry_in;
    // Strict compares keep the earlier (lower) slot on a full tie.
    better = !carry_in.found || (due < carry_in.due) ||
             ((due == carry_in.due) && (handle < carry_in.handle));
    if (carry_in.active) begin
      case (carry_in.op)
        OP_SCHED: begin
          if (!carry_in.found && !valid_eff) begin
            valid_next       = 1'b1;
            due_next         = carry_in.due;
            handle_next      = carry_in.handle;
            carry_next.found = 1'b1;
            carry_next.idx   = my_idx;
          end
        end
        OP_CANCEL: begin
          if (!carry_in.found && valid_eff && (handle == carry_in.handle)) begin
            valid_next       = 1'b0;
            carry_next.found = 1'b1;
            carry_next.idx   = my_idx;
          end
        end
        OP_EXPIRE: begin
          if (valid_eff && (due <= now_ms) && better) begin
            carry_next.found  = 1'b1;
            carry_next.due    = due;
            carry_next.handle = handle;
            carry_next.idx    = my_idx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      carry_out <= '0;
    end else begin
      valid     <= valid_next;
      carry_out <= carry_next;
    end
    due    <= due_next;
    handle <= handle_next;
  end

endmodule

// ===== hdl/otq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_ctrl
// Request sequencer: keeps the clock and handle counter, launches tokens
// into the cell row and turns returning tokens into results.
// ----------------------------------------------------------------------------
module otq_ctrl
  import otq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    request,
  output logic    busy,
  output logic    strobe,
  output rsp_t    result,
  output tstamp_t now_ms,
  output carry_t  launch,
  input  carry_t  carry_ret
);

  state_t               state, state_next;
  logic [31:0]          next_id, id_next;
  tstamp_t              now_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  logic [31:0]          held, held_next;
  logic                 have_held, have_held_next;
  carry_t               launch_next;
  logic                 strobe_next;
  rsp_t                 result_next;
  op_t                  op, op_next;

  logic [TIME_BITS:0]   tick_sum;
  logic [TIME_BITS:0]   sched_sum;
  logic [31:0]          id_plus;

  assign busy = (state != ST_IDLE);

  always_comb begin
    tick_sum  = {1'b0, now_ms} + {{TIME_BITS{1'b0}}, 1'b1};
    sched_sum = {1'b0, now_ms} + {{(TIME_BITS + 1 - 32){1'b0}}, request.delay_ms};
    id_plus   = next_id + 32'd1;
  end

  always_comb begin
    state_next     = state;
    id_next        = next_id;
    now_next       = now_ms;
    cnt_next       = cnt;
    held_next      = held;
    have_held_next = have_held;
    op_next        = op;
    launch_next    = '0;
    strobe_next    = 1'b0;
    result_next    = result;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (request.req_type)
            REQ_TICK: begin
              now_next           = tick_sum[TIME_BITS] ? TIME_MAX : tick_sum[TIME_BITS-1:0];
              cnt_next           = '0;
              have_held_next     = 1'b0;
              op_next            = OP_EXPIRE;
              launch_next.active = 1'b1;
              launch_next.op     = OP_EXPIRE;
              state_next         = ST_WAVE;
            end
            REQ_SCHED: begin
              op_next            = OP_SCHED;
              launch_next.active = 1'b1;
              launch_next.op     = OP_SCHED;
              launch_next.due    = sched_sum[TIME_BITS] ? TIME_MAX
                                                        : sched_sum[TIME_BITS-1:0];
              launch_next.handle = next_id;
              state_next         = ST_WAVE;
            end
            REQ_CANCEL: begin
              op_next            = OP_CANCEL;
              launch_next.active = 1'b1;
              launch_next.op     = OP_CANCEL;
              launch_next.handle = request.target_handle;
              state_next         = ST_WAVE;
            end
            default: ;
          endcase
        end
      end
      ST_WAVE: begin
        if (carry_ret.active) begin
          unique case (op)
            OP_SCHED: begin
              strobe_next              = 1'b1;
              result_next.kind         = KIND_SCHED;
              result_next.timer_handle = carry_ret.found ? carry_ret.handle : 32'd0;
              result_next.status       = carry_ret.found ? STAT_OK : STAT_FULL;
              result_next.last         = 1'b1;
              if (carry_ret.found) begin
                id_next = (id_plus == 32'd0) ? 32'd1 : id_plus;
              end
              state_next = ST_IDLE;
            end
            OP_CANCEL: begin
              strobe_next              = 1'b1;
              result_next.kind         = KIND_CANCEL;
              result_next.timer_handle = carry_ret.found ? carry_ret.handle : 32'd0;
              result_next.status       = carry_ret.found ? STAT_OK : STAT_NOT_FOUND;
              result_next.last         = 1'b1;
              state_next               = ST_IDLE;
            end
            default: begin
              // An expiry is held back until the next pass shows whether it
              // is the final one. Each new pass frees the slot just found.
              result_next.kind         = KIND_EXPIRE;
              result_next.timer_handle = held;
              result_next.status       = STAT_OK;
              strobe_next              = have_held;
              if (carry_ret.found && (cnt < CNT_BITS'(MAX_RESULTS))) begin
                result_next.last     = 1'b0;
                held_next            = carry_ret.handle;
                have_held_next       = 1'b1;
                cnt_next             = cnt + 1'b1;
                launch_next.active   = 1'b1;
                launch_next.op       = OP_EXPIRE;
                launch_next.kill     = 1'b1;
                launch_next.kill_idx = carry_ret.idx;
              end else begin
                result_next.last = 1'b1;
                have_held_next   = 1'b0;
                state_next       = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_id   <= 32'd1;
      now_ms    <= '0;
      cnt       <= '0;
      have_held <= 1'b0;
      op        <= OP_SCHED;
      launch    <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      next_id   <= id_next;
      now_ms    <= now_next;
      cnt       <= cnt_next;
      have_held <= have_held_next;
      op        <= op_next;
      launch    <= launch_next;
      strobe    <= strobe_next;
    end
    held   <= held_next;
    result <= result_next;
  end

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(MAX_RESULTS))
    else $error("expiry count beyond limit");

  a_sched_handle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_SCHED && result.status == STAT_OK)
      |-> (result.timer_handle != 32'd0))
    else $error("schedule reply with handle zero");

  a_next_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != 32'd0)
    else $error("handle counter reached zero");

endmodule

// ===== hdl/one_shot_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_queue
// Table of pending one-shot timers kept in a row of slot cells.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low. Tick
// advances the saturating millisecond clock and reports every due timer in
// order of due time, then handle; schedule stores a timer and returns its
// handle; cancel frees the slot holding a handle.
// Results appear on result for one cycle with strobe high; the receiver
// cannot stall, so no result is ever held off. last marks the final result
// of a transaction.
// Each request sends a token down the cell row, one cell per cycle, from the
// launch register through every slot cell and back to the sequencer.
// Schedule and cancel put their reply on result after one pass. A tick that
// finds k timers due runs k + 1 passes and gives its final result after the
// last pass; a tick with nothing due gives no result and frees busy after
// one pass. Busy drops in the cycle of the final result, when the next
// request may be taken.
// Reset clears all slots, sets the clock to zero and the next handle to one.
// ----------------------------------------------------------------------------
module one_shot_timer_queue
  import otq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic strobe,
  output rsp_t result
);

  carry_t  chain [SLOTS+1];
  tstamp_t now_ms;

  otq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .now_ms    (now_ms),
    .launch    (chain[0]),
    .carry_ret (chain[SLOTS])
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    otq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .my_idx    (IDX_BITS'(i)),
      .now_ms    (now_ms),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

endmodule

// ===== test/otq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_checker
// Predicts and checks the results of the one-shot timer queue.
// ----------------------------------------------------------------------------
// Watches the request and result channels of the block. Every accepted
// request transaction is run through a local copy of the timer table, and
// the results that it causes are queued. Every strobed result is compared,
// field by field, with the oldest queued result. The number of failures and
// the number of results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module otq_checker
  import otq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  rsp_t result,
  output int   errors,
  output int   outstanding
);

  logic        live   [SLOTS];
  tstamp_t     due_at [SLOTS];
  logic [31:0] owner  [SLOTS];
  tstamp_t     now_ms;
  logic [31:0] next_handle;
  rsp_t        owed_results[$];
  rsp_t        oldest;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic owe_result(input rsp_t r);
    owed_results = {owed_results, r};
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
    now_ms      = '0;
    next_handle = 32'd1;
    owed_results.delete();
  endtask

  task automatic apply_request(input req_t r);
    logic [TIME_BITS:0] sum;
    rsp_t               reply;
    rsp_t               held;
    bit                 have;
    bit                 searching;
    int                 slot;
    int                 best;
    reply = '0;
    held  = '0;
    have  = 1'b0;
    case (r.req_type)
      REQ_SCHED: begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) slot = i;
        reply.kind = KIND_SCHED;
        reply.last = 1'b1;
        if (slot < 0) begin
          reply.status = STAT_FULL;
        end else begin
          // The due time saturates at the top of the clock range.
          sum = {1'b0, now_ms} + {{(TIME_BITS + 1 - 32){1'b0}}, r.delay_ms};
          live[slot]   = 1'b1;
          due_at[slot] = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
          owner[slot]  = next_handle;
          reply.timer_handle = next_handle;
          reply.status       = STAT_OK;
          next_handle = next_handle + 32'd1;
          if (next_handle == 32'd0) next_handle = 32'd1;
        end
        owe_result(reply);
      end
      REQ_CANCEL: begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (live[i] && owner[i] == r.target_handle) slot = i;
        reply.kind = KIND_CANCEL;
        reply.last = 1'b1;
        if (slot < 0) begin
          reply.status = STAT_NOT_FOUND;
        end else begin
          live[slot]         = 1'b0;
          reply.timer_handle = r.target_handle;
          reply.status       = STAT_OK;
        end
        owe_result(reply);
      end
      REQ_TICK: begin
        if (now_ms != TIME_MAX) now_ms = now_ms + 1'b1;
        searching = 1'b1;
        // Earliest due time first, then lower handle, then lower slot.
        for (int n = 0; n < MAX_RESULTS && searching; n++) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i] && due_at[i] <= now_ms) begin
              if (best < 0 || due_at[i] < due_at[best] ||
                  (due_at[i] == due_at[best] && owner[i] < owner[best]))
                best = i;
            end
          end
          if (best < 0) begin
            searching = 1'b0;
          end else begin
            live[best] = 1'b0;
            if (have) owe_result(held);
            held              = '0;
            held.kind         = KIND_EXPIRE;
            held.timer_handle = owner[best];
            held.status       = STAT_OK;
            have              = 1'b1;
          end
        end
        if (have) begin
          held.last = 1'b1;
          owe_result(held);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
    end else begin
      if (strobe) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d handle %0d status %0d",
                                  result.kind, result.timer_handle, result.status));
        end else begin
          oldest = owed_results.pop_front();
          if (result.kind !== oldest.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", result.kind, oldest.kind));
          if (result.timer_handle !== oldest.timer_handle)
            flag_mismatch($sformatf("timer_handle %0d, expected %0d",
                                    result.timer_handle, oldest.timer_handle));
          if (result.status !== oldest.status)
            flag_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, oldest.status));
          if (result.last !== oldest.last)
            flag_mismatch($sformatf("last %0d, expected %0d", result.last, oldest.last));
        end
      end
      if (start && !busy) apply_request(request);
    end
    outstanding <= owed_results.size();
  end

endmodule

// ===== test/one_shot_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_queue_tb
// Testbench of the one-shot timer queue.
// ----------------------------------------------------------------------------
// Drives a directed run through empty ticks, ordering of equal due times,
// cancel hits and misses, a full table and a tick that expires every slot,
// then a long random mix of schedules, ticks and cancels with random gaps.
// The checker beside the block predicts and compares every result; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module one_shot_timer_queue_tb;
  import otq_pkg::*;

  // Results of one tick come one pass apart, and a reply comes one pass after
  // its request, so a correct run stays quiet for long only in the final drain
  // of DRAIN_CYCLES. The limit is several times that.
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 430;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic strobe;
  req_t request;
  rsp_t result;
  int   errors;
  int   outstanding;
  int   quiet_cycles = 0;
  bit   no_idle;
  int   sched_sent;
  int   burst_left;
  logic [31:0] burst_delay;

  one_shot_timer_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

  otq_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .strobe      (strobe),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] delay,
                                    input logic [31:0] target);
    req_t r;
    r.req_type      = kind;
    r.delay_ms      = delay;
    r.target_handle = target;
    return r;
  endfunction

  // Offers one request transaction after a random gap and returns at the
  // edge that takes it. start stays high when the next gap is zero.
  task automatic issue(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    if (r.req_type == REQ_SCHED) sched_sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] delay;
    logic [31:0] target;
    pick = $urandom_range(0, 99);
    if (burst_left == 0 && pick < 3) begin
      // A run of schedules with one delay gives ticks with many expiries.
      burst_left  = $urandom_range(3, 10);
      burst_delay = $urandom_range(0, 8);
    end
    if (burst_left > 0) begin
      burst_left--;
      issue(make_req(REQ_SCHED, burst_delay, $urandom));
    end else if (pick < 36) begin
      if ($urandom_range(0, 99) < 4) delay = $urandom;
      else if ($urandom_range(0, 3) == 0) delay = $urandom_range(0, 200);
      else delay = $urandom_range(0, 20);
      issue(make_req(REQ_SCHED, delay, $urandom));
    end else if (pick < 72) begin
      issue(make_req(REQ_TICK, $urandom, $urandom));
    end else if (pick < 94) begin
      // Mostly recent handles, so that many cancels hit a pending timer.
      if ($urandom_range(0, 3) == 0 || sched_sent <= 20)
        target = $urandom_range(0, sched_sent + 1);
      else
        target = sched_sent - $urandom_range(0, 20);
      issue(make_req(REQ_CANCEL, $urandom, target));
    end else if (pick < 97) begin
      issue(make_req(REQ_CANCEL, $urandom, $urandom));
    end else begin
      issue(make_req(REQ_NOP, $urandom, $urandom));
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    request    <= '0;
    no_idle    = 1'b0;
    sched_sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    issue(make_req(REQ_TICK, 32'd0, 32'd0));
    issue(make_req(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    issue(make_req(REQ_CANCEL, 32'd0, 32'd0));
    issue(make_req(REQ_CANCEL, 32'd0, 32'hFFFF_FFFF));
    issue(make_req(REQ_SCHED, 32'd0, 32'd0));
    issue(make_req(REQ_TICK, 32'd0, 32'd0));
    issue(make_req(REQ_SCHED, 32'hFFFF_FFFF, 32'd0));
    // Two timers with one due time and an earlier one behind them.
    issue(make_req(REQ_SCHED, 32'd1, 32'd0));
    issue(make_req(REQ_SCHED, 32'd1, 32'd0));
    issue(make_req(REQ_SCHED, 32'd0, 32'd0));
    issue(make_req(REQ_TICK, 32'd0, 32'd0));
    issue(make_req(REQ_CANCEL, 32'd0, 32'd2));
    issue(make_req(REQ_CANCEL, 32'd0, 32'd2));
    // Fill the table, overflow it once, then expire every slot in one tick.
    for (int i = 0; i < SLOTS; i++) issue(make_req(REQ_SCHED, 32'd2, 32'd0));
    issue(make_req(REQ_SCHED, 32'd5, 32'd0));
    issue(make_req(REQ_TICK, 32'd0, 32'd0));
    issue(make_req(REQ_TICK, 32'd0, 32'd0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 100 == 50) wait_for_results();
      random_item();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
